>>> rtl/core/kth_successor_binary_lifting_assert.svh
// Assertion macros for the k-th successor block.
// Immediate-cycle and next-cycle implication checks, empty under SYNTHESIS.
`ifndef KTH_SUCCESSOR_BINARY_LIFTING_ASSERT_SVH
`define KTH_SUCCESSOR_BINARY_LIFTING_ASSERT_SVH
`ifndef SYNTHESIS
`define KSBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksbl assertion failed (same cycle)");
`define KSBL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksbl assertion failed (next cycle)");
`else
`define KSBL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KSBL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/ksbl_pkg.sv
// Shared constants for the k-th successor block.
// No dependencies.
package ksbl_pkg;

    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 30;

    // Fixed field widths
    localparam int NODE_W = 10;
    localparam int STEP_W = 30;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

>>> rtl/core/kth_successor_binary_lifting.sv
// Top level of the k-th successor block (binary lifting over a successor table).
// Depends on ksbl_pkg, ksbl_ram and kth_successor_binary_lifting_assert.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  command | in        | start & !busy              | i_cmd, i_node, i_next_node, i_steps
//  result  | out       | o_done (one-cycle strobe)  | o_dest_node, o_bad_index
//  config  | in        | i_cfg_valid & o_cfg_ready  | i_cfg_data (node_count)
//
// A valid load writes level zero in its accept cycle and leaves busy low; a rejected
// load or a bad start node gives its result in the cycle after accept.
// A query holds busy while S_BCHK builds any level still missing up to its highest step
// bit, then S_WALK and S_WDATA take one jump per set step bit; the result follows.
// Each missing level takes two reads and one write per entry (S_BRD0, S_BRD1, S_BWR).
// Reset is synchronous; the table needs no clearing pass. Results cannot be stalled.

`include "kth_successor_binary_lifting_assert.svh"

module kth_successor_binary_lifting
    import ksbl_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cmd,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_next_node,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [NODE_W-1:0] o_dest_node,
    output logic              o_bad_index,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int LVL_USE = (LEVELS < STEP_W) ? LEVELS : STEP_W;
    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEPTH   = LEVELS * NODES;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_CAP = (NODES > 2047) ? 2047 : NODES;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BCHK,
        S_BRD0,
        S_BRD1,
        S_BWR,
        S_WALK,
        S_WDATA
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_node_count, n_node_count;
    logic [LVL_W-1:0]   r_lvl_ready, n_lvl_ready;
    logic [LVL_W-1:0]   r_top, n_top;
    logic [LVL_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [NODE_W-1:0]  r_cur, n_cur;
    logic [LVL_USE-1:0] r_steps, n_steps;
    logic               r_done, n_done;
    logic [NODE_W-1:0]  r_dest, n_dest;
    logic               r_bad, n_bad;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [NODE_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]   limit;
    logic               cmd_xfer;
    logic               cfg_xfer;
    logic               node_bad;
    logic               next_bad;
    logic               rdata_bad;
    logic [LVL_W-1:0]   in_top;

    // Table address of one node at one level
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [31:0] nd);
        tbl_addr = ADDR_W'(32'(lvl) * 32'(NODES) + nd);
    endfunction

    ksbl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Limit in force is the smaller of node_count and NODES
    assign limit = (r_node_count < CNT_W'(LIM_CAP)) ? r_node_count : CNT_W'(LIM_CAP);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cmd_xfer    = start && !busy;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign node_bad    = ({1'b0, i_node} >= limit);
    assign next_bad    = ({1'b0, i_next_node} >= limit);
    assign rdata_bad   = ({1'b0, ram_rdata} >= limit);

    assign o_done      = r_done;
    assign o_dest_node = r_dest;
    assign o_bad_index = r_bad;

    // Highest set step bit below the level count
    always_comb begin
        in_top = '0;
        for (int b = 0; b < LVL_USE; b++) begin
            if (i_steps[b]) begin
                in_top = LVL_W'(b);
            end
        end
    end

    // Sequencer and table port control
    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_lvl_ready  = r_lvl_ready;
        n_top        = r_top;
        n_j          = r_j;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_done       = 1'b0;
        n_dest       = r_dest;
        n_bad        = r_bad;
        ram_we       = 1'b0;
        ram_waddr    = tbl_addr(LVL_W'(r_lvl_ready + 1'b1), 32'(r_idx));
        ram_wdata    = ram_rdata;
        ram_raddr    = tbl_addr(r_lvl_ready, 32'(r_idx));

        case (r_state)
            S_IDLE: begin
                if (cfg_xfer) begin
                    n_node_count = i_cfg_data;
                    n_lvl_ready  = '0;
                end
                if (cmd_xfer) begin
                    if (i_cmd == CMD_LOAD) begin
                        if (node_bad || next_bad) begin
                            n_done = 1'b1;
                            n_dest = '0;
                            n_bad  = 1'b1;
                        end else begin
                            // Write level zero and drop all levels built above it
                            ram_we      = 1'b1;
                            ram_waddr   = tbl_addr('0, 32'(i_node));
                            ram_wdata   = i_next_node;
                            n_lvl_ready = '0;
                        end
                    end else if (node_bad) begin
                        n_done = 1'b1;
                        n_dest = '0;
                        n_bad  = 1'b1;
                    end else begin
                        n_cur   = i_node;
                        n_steps = i_steps[LVL_USE-1:0];
                        n_top   = in_top;
                        n_j     = '0;
                        n_state = S_BCHK;
                    end
                end
            end
            S_BCHK: begin
                if (r_lvl_ready < r_top) begin
                    n_idx   = '0;
                    n_state = S_BRD0;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_BRD0: begin
                // Read the level entry of this node
                n_state = S_BRD1;
            end
            S_BRD1: begin
                // Read the level entry of the middle node
                ram_raddr = tbl_addr(r_lvl_ready, 32'(ram_rdata));
                n_state   = S_BWR;
            end
            S_BWR: begin
                // Store the composed entry one level up
                ram_we = 1'b1;
                if (r_idx == IDX_W'(NODES - 1)) begin
                    n_lvl_ready = r_lvl_ready + 1'b1;
                    n_state     = S_BCHK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_BRD0;
                end
            end
            S_WALK: begin
                ram_raddr = tbl_addr(r_j, 32'(r_cur));
                if (r_steps == '0) begin
                    n_done  = 1'b1;
                    n_dest  = r_cur;
                    n_bad   = 1'b0;
                    n_state = S_IDLE;
                end else if (r_steps[0]) begin
                    n_state = S_WDATA;
                end else begin
                    n_steps = r_steps >> 1;
                    n_j     = r_j + 1'b1;
                end
            end
            S_WDATA: begin
                // Take the jump, stop on an out-of-range node
                if (rdata_bad) begin
                    n_done  = 1'b1;
                    n_dest  = '0;
                    n_bad   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cur   = ram_rdata;
                    n_steps = r_steps >> 1;
                    n_j     = r_j + 1'b1;
                    n_state = S_WALK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RST;
            r_lvl_ready  <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_lvl_ready  <= n_lvl_ready;
            r_done       <= n_done;
        end
        r_top   <= n_top;
        r_j     <= n_j;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_dest  <= n_dest;
        r_bad   <= n_bad;
    end

    // Checks
    `KSBL_ASSERT_IMP(a_done_src, i_clk, i_rst_n, o_done, $past(busy) || $past(start))
    `KSBL_ASSERT_NXT(a_load_no_busy, i_clk, i_rst_n, cmd_xfer && (i_cmd == CMD_LOAD), !busy)
    `KSBL_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_done && o_bad_index, o_dest_node == '0)
    `KSBL_ASSERT_NXT(a_cfg_clear, i_clk, i_rst_n, cfg_xfer, r_lvl_ready == '0)
    `KSBL_ASSERT_IMP(a_build_need, i_clk, i_rst_n,
        (r_state == S_BRD0) || (r_state == S_BRD1) || (r_state == S_BWR),
        r_lvl_ready < r_top)

endmodule

>>> rtl/core/ksbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ksbl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
